// ----- rtl/core/pfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared types and codes for the pid filter slot allocator: command and
// status codes, owner codes and the records passed along the cell chain.
// ----------------------------------------------------------------------------
package pfsa_pkg;

   localparam int PID_W     = 13;
   localparam int SLOT_W    = 8;
   localparam int CNT_W     = 9;
   localparam int OP_W      = 3;
   localparam int ST_W      = 3;
   localparam int OWN_W     = 2;
   localparam int CFG_W     = 6;
   localparam int IDX_OUT_W = 5;

   localparam logic [PID_W-1:0] FREE_PID  = 13'h1fff;
   localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

   // commands
   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE_CK = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE_UN = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_BYPASS  = 3'd4;

   // status
   localparam logic [ST_W-1:0] ST_OK     = 3'd0;
   localparam logic [ST_W-1:0] ST_DUP    = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
   localparam logic [ST_W-1:0] ST_BADIDX = 3'd3;
   localparam logic [ST_W-1:0] ST_OWNER  = 3'd4;

   // owners
   localparam logic [OWN_W-1:0] OWN_NONE   = 2'd0;
   localparam logic [OWN_W-1:0] OWN_LEGACY = 2'd1;
   localparam logic [OWN_W-1:0] OWN_DVB    = 2'd2;

   // table update codes
   localparam logic [1:0] CM_NONE    = 2'd0;
   localparam logic [1:0] CM_ALLOC   = 2'd1;
   localparam logic [1:0] CM_RELEASE = 2'd2;
   localparam logic [1:0] CM_CLEAR   = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   op;
      logic [PID_W-1:0]  pid;
      logic              dvb;
      logic [SLOT_W-1:0] slot;
      logic              bypass_on;
      logic              dup;
      logic              free_found;
      logic [SLOT_W-1:0] free_idx;
      logic [OWN_W-1:0]  slot_owner;
   } flow_type;

   typedef struct packed {
      logic [1:0]        code;
      logic [SLOT_W-1:0] idx;
      logic [PID_W-1:0]  pid;
      logic [OWN_W-1:0]  owner;
   } commit_type;

   typedef struct packed {
      logic [ST_W-1:0]      status;
      logic [IDX_OUT_W-1:0] idx;
      logic                 bypass;
   } result_type;

endpackage

// ----- rtl/core/pfsa_cell.sv -----
// ----------------------------------------------------------------------------
// pfsa_cell
// One filter slot: holds enable, pid and owner, checks the passing
// transaction against its entry and hands the record to the next cell.
// ----------------------------------------------------------------------------
module pfsa_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pfsa_pkg::CNT_W-1:0]     n_active,
   input  pfsa_pkg::flow_type             flow_in,
   input  pfsa_pkg::commit_type           commit,
   output pfsa_pkg::flow_type             flow_out
);

   localparam logic [pfsa_pkg::CNT_W-1:0]  IDX_CNT  = pfsa_pkg::CNT_W'(CELL_INDEX);
   localparam logic [pfsa_pkg::SLOT_W-1:0] IDX_SLOT = pfsa_pkg::SLOT_W'(CELL_INDEX);

   logic                          enabled_ff;
   logic [pfsa_pkg::PID_W-1:0]    pid_ff;
   logic [pfsa_pkg::OWN_W-1:0]    owner_ff;
   pfsa_pkg::flow_type            flow_ff;
   pfsa_pkg::flow_type            flow_in_nx;
   logic                          active;
   logic                          hit_idx;

   assign active  = IDX_CNT < n_active;
   assign hit_idx = commit.idx == IDX_SLOT;

   always_comb begin
      flow_in_nx = flow_in;
      if (active && pid_ff == flow_in.pid) begin
         flow_in_nx.dup = 1'b1;
      end
      if (active && !enabled_ff && !flow_in.free_found) begin
         flow_in_nx.free_found = 1'b1;
         flow_in_nx.free_idx   = IDX_SLOT;
      end
      if (flow_in.slot == IDX_SLOT) begin
         flow_in_nx.slot_owner = owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_ff.valid <= 1'b0;
      end else begin
         flow_ff <= flow_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         pid_ff     <= pfsa_pkg::FREE_PID;
         owner_ff   <= pfsa_pkg::OWN_NONE;
      end else begin
         case (commit.code)
            pfsa_pkg::CM_ALLOC: begin
               if (hit_idx) begin
                  enabled_ff <= 1'b1;
                  pid_ff     <= commit.pid;
                  owner_ff   <= commit.owner;
               end
            end
            pfsa_pkg::CM_RELEASE: begin
               if (hit_idx) begin
                  enabled_ff <= 1'b0;
                  pid_ff     <= pfsa_pkg::FREE_PID;
                  owner_ff   <= pfsa_pkg::OWN_NONE;
               end
            end
            pfsa_pkg::CM_CLEAR: begin
               if (active && enabled_ff) begin
                  enabled_ff <= 1'b0;
                  pid_ff     <= pfsa_pkg::FREE_PID;
                  owner_ff   <= pfsa_pkg::OWN_NONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign flow_out = flow_ff;

endmodule

// ----- rtl/core/pid_filter_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// pid_filter_slot_allocator
// Table of transport stream pid filter slots with duplicate-checked
// allocate, checked and unchecked free, clear-all and a bypass flag.
// ----------------------------------------------------------------------------
// Each slot is a cell in a chain, and a transaction walks the chain one cell
// per cycle collecting the duplicate flag, the lowest free slot and the owner
// of the addressed slot; at the end of the chain the table update is
// broadcast to all cells. One transaction is handled at a time: the result
// passes from the last cell to the pending register and then to the output
// register, and the next request is taken when it leaves the pending
// register. A finished response waits in the output register while the
// next transaction is accepted. csr_wr_data sets the number of active slots
// (reset 32, capped at MAX_SLOTS).
// ----------------------------------------------------------------------------
module pid_filter_slot_allocator #(
   parameter int MAX_SLOTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [pfsa_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pfsa_pkg::OP_W-1:0]         req_opcode,
   input  logic [pfsa_pkg::PID_W-1:0]        req_pid,
   input  logic                              req_owner_dvb,
   input  logic [pfsa_pkg::SLOT_W-1:0]       req_slot,
   input  logic                              req_bypass_on,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pfsa_pkg::ST_W-1:0]         rsp_status,
   output logic [pfsa_pkg::IDX_OUT_W-1:0]    rsp_slot_index,
   output logic                              rsp_bypass_state
);

   localparam logic [pfsa_pkg::CNT_W-1:0] CAP = pfsa_pkg::CNT_W'(MAX_SLOTS);

   logic [pfsa_pkg::CFG_W-1:0]  fiu_ff;
   logic                        bypass_ff;
   logic                        busy_ff;
   logic                        pend_valid_ff;
   pfsa_pkg::result_type        pend_ff;
   logic                        rsp_valid_ff;
   pfsa_pkg::result_type        rsp_ff;

   logic [pfsa_pkg::CNT_W-1:0]  fiu_ext;
   logic [pfsa_pkg::CNT_W-1:0]  n_active;
   pfsa_pkg::flow_type          chain [MAX_SLOTS+1];
   logic [MAX_SLOTS-1:0]        chain_vld;
   pfsa_pkg::flow_type          tail;
   pfsa_pkg::commit_type        commit;
   pfsa_pkg::result_type        res;
   logic                        bypass_in;
   logic                        slot_ok;
   logic                        accept;
   logic                        pend_move;

   assign fiu_ext  = pfsa_pkg::CNT_W'(fiu_ff);
   assign n_active = (fiu_ext > CAP) ? CAP : fiu_ext;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   // transaction enters the chain
   always_comb begin
      chain[0]            = '0;
      chain[0].valid      = accept;
      chain[0].op         = req_opcode;
      chain[0].pid        = req_pid;
      chain[0].dvb        = req_owner_dvb;
      chain[0].slot       = req_slot;
      chain[0].bypass_on  = req_bypass_on;
      chain[0].slot_owner = pfsa_pkg::OWN_NONE;
   end

   for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
      pfsa_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .n_active (n_active),
         .flow_in  (chain[g]),
         .commit   (commit),
         .flow_out (chain[g+1])
      );
      assign chain_vld[g] = chain[g+1].valid;
   end

   assign tail    = chain[MAX_SLOTS];
   assign slot_ok = {1'b0, tail.slot} < n_active;

   // result and table update at the end of the chain
   always_comb begin
      res        = '0;
      res.status = pfsa_pkg::ST_OK;
      commit       = '0;
      commit.code  = pfsa_pkg::CM_NONE;
      commit.pid   = tail.pid;
      commit.owner = tail.dvb ? pfsa_pkg::OWN_DVB : pfsa_pkg::OWN_LEGACY;
      bypass_in    = bypass_ff;
      if (tail.valid) begin
         unique case (tail.op)
            pfsa_pkg::OP_ALLOC: begin
               if (tail.dup) begin
                  res.status = pfsa_pkg::ST_DUP;
               end else if (!tail.free_found) begin
                  res.status = pfsa_pkg::ST_FULL;
               end else begin
                  res.idx     = tail.free_idx[pfsa_pkg::IDX_OUT_W-1:0];
                  commit.code = pfsa_pkg::CM_ALLOC;
                  commit.idx  = tail.free_idx;
               end
            end
            pfsa_pkg::OP_FREE_CK: begin
               if (!slot_ok) begin
                  res.status = pfsa_pkg::ST_BADIDX;
               end else if (tail.slot_owner != pfsa_pkg::OWN_LEGACY) begin
                  res.status = pfsa_pkg::ST_OWNER;
               end else begin
                  res.idx     = tail.slot[pfsa_pkg::IDX_OUT_W-1:0];
                  commit.code = pfsa_pkg::CM_RELEASE;
                  commit.idx  = tail.slot;
               end
            end
            pfsa_pkg::OP_FREE_UN: begin
               if (!slot_ok) begin
                  res.status = pfsa_pkg::ST_BADIDX;
               end else begin
                  res.idx     = tail.slot[pfsa_pkg::IDX_OUT_W-1:0];
                  commit.code = pfsa_pkg::CM_RELEASE;
                  commit.idx  = tail.slot;
               end
            end
            pfsa_pkg::OP_CLEAR: begin
               commit.code = pfsa_pkg::CM_CLEAR;
            end
            pfsa_pkg::OP_BYPASS: begin
               bypass_in = tail.bypass_on;
            end
            default: begin
            end
         endcase
      end
      res.bypass = bypass_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff        <= pfsa_pkg::CFG_RESET;
         bypass_ff     <= 1'b0;
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fiu_ff <= csr_wr_data;
         end
         bypass_ff <= bypass_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (pend_move) begin
            busy_ff <= 1'b0;
         end
         if (tail.valid) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         pend_ff <= res;
      end
      if (pend_move) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_slot_index   = rsp_ff.idx;
   assign rsp_bypass_state = rsp_ff.bypass;

   // only one transaction in the chain at a time
   a_one_in_chain: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_vld))
      else $error("more than one transaction in the cell chain");

   // a transaction in the chain always belongs to a busy block
   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      (chain_vld != '0) |-> busy_ff)
      else $error("transaction in chain while not busy");

   // end of chain always lands in the pending register
   a_tail_pend: assert property (@(posedge clock) disable iff (reset)
      tail.valid |=> pend_valid_ff)
      else $error("finished transaction lost");

   // errors never report a slot
   a_err_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != pfsa_pkg::ST_OK) |-> (rsp_slot_index == '0))
      else $error("error response with a slot index");

endmodule
